// ----- hdl/ctc_pkg.sv -----
// shared types and constants for the columnar transposition cipher unit
`default_nettype none
package ctc_pkg;

  localparam int CTC_MAX_LEN = 32;
  localparam int COLS_W      = 6;
  localparam logic [7:0] PAD_CHAR = 8'h65;

  // register indexes on the configuration port
  localparam logic REG_COLUMNS   = 1'b0;
  localparam logic REG_DIRECTION = 1'b1;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } ctc_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
    logic       overflow;
  } ctc_out_t;

  typedef struct packed {
    logic [COLS_W-1:0] columns;
    logic              direction;
  } ctc_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_DRAIN
  } ctc_state_t;

endpackage
`default_nettype wire

// ----- hdl/columnar_transposition_cipher_unit.sv -----
// top level of the columnar transposition cipher unit
//
// Input: a message arrives one byte per transaction on in_item, taken at a
// clock edge with start high and busy low. Non-final bytes leave busy low,
// so the next byte can follow. Bytes beyond MAX_LEN are dropped and flagged.
// When the byte with in_last arrives the block goes busy: it first counts
// rows by adding the column count to an accumulator, one add per cycle,
// then walks the padded block of len = columns * rows positions with the
// selected stride, one memory read per cycle, and ends in a drain state.
// Output: each result is on out_item for one cycle with out_valid high,
// starting in the cycle after the walk begins; out_last marks the last
// result and overflow is set on all results of a message that lost bytes.
// The receiver cannot stall; results are never held back.
// Configuration: APB registers columns (0x0) and direction (0x4); the user
// must write them only while idle (not enforced); sampled at the final byte.
// Reset: synchronous active-low rst_n empties the message buffer, clears
// the overflow flag and sets columns to 1, direction to encrypt.
`default_nettype none
module columnar_transposition_cipher_unit #(
  parameter int MAX_LEN = ctc_pkg::CTC_MAX_LEN
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire ctc_pkg::ctc_in_t in_item,
  output logic                  out_valid,
  output ctc_pkg::ctc_out_t     out_item,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);
  import ctc_pkg::*;

  ctc_cfg_t cfg;

  ctc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ctc_seq #(
    .MAX_LEN (MAX_LEN)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg       (cfg)
  );

endmodule
`default_nettype wire

// ----- hdl/ctc_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none
module ctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/ctc_alu.sv -----
// shared adder and limit compare used for row count and read address stepping
`default_nettype none
module ctc_alu #(
  parameter int W = 7
) (
  input  wire logic [W-1:0] op_a,
  input  wire logic [W-1:0] op_b,
  input  wire logic [W-1:0] limit,
  output logic      [W:0]   sum,
  output logic              reached
);

  assign sum     = {1'b0, op_a} + {1'b0, op_b};
  assign reached = (sum >= {1'b0, limit});

endmodule
`default_nettype wire

// ----- hdl/ctc_cfg.sv -----
// apb register file holding column count and direction
`default_nettype none
module ctc_cfg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output ctc_pkg::ctc_cfg_t      cfg
);
  import ctc_pkg::*;

  logic [COLS_W-1:0] columns_r;
  logic              direction_r;
  logic              wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r   <= COLS_W'(1);
      direction_r <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_COLUMNS:   columns_r   <= pwdata[COLS_W-1:0];
        REG_DIRECTION: direction_r <= pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COLUMNS:   prdata = {{(32-COLS_W){1'b0}}, columns_r};
      REG_DIRECTION: prdata = {31'b0, direction_r};
      default:       prdata = 32'b0;
    endcase
  end

  assign cfg.columns   = columns_r;
  assign cfg.direction = direction_r;

endmodule
`default_nettype wire

// ----- hdl/ctc_seq.sv -----
// sequencer: message load, iterative row count, strided readout
`default_nettype none
module ctc_seq #(
  parameter int MAX_LEN = ctc_pkg::CTC_MAX_LEN
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ctc_pkg::ctc_in_t  in_item,
  output logic                   out_valid,
  output ctc_pkg::ctc_out_t      out_item,
  input  wire ctc_pkg::ctc_cfg_t cfg
);
  import ctc_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int PW = $clog2(MAX_LEN + 64);

  ctc_state_t state_r, state_nxt;

  logic [LW-1:0]     len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic [COLS_W-1:0] cols_r, cols_nxt;
  logic              dir_r, dir_nxt;
  logic [PW-1:0]     acc_r, acc_nxt;
  logic [LW-1:0]     rows_r, rows_nxt;
  logic [PW-1:0]     stride_r, stride_nxt;
  logic [PW-1:0]     pos_r, pos_nxt;
  logic [PW-1:0]     base_r, base_nxt;
  logic [PW-1:0]     cnt_r, cnt_nxt;
  logic              vld_r, vld_nxt;
  logic              pad_r, pad_nxt;
  logic              last_r, last_nxt;
  logic              oflag_r, oflag_nxt;

  logic              accept;
  logic              ram_we;
  logic [7:0]        ram_rdata;
  logic [PW-1:0]     alu_a, alu_b, alu_limit;
  logic [PW:0]       alu_sum;
  logic              alu_reached;
  logic              is_last;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign ram_we = accept && (len_r < LW'(MAX_LEN));
  assign is_last = ((cnt_r + PW'(1)) == acc_r);

  ctc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[AW-1:0]),
    .wdata (in_item.in_char),
    .raddr (pos_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // one adder serves the row count loop and the address walk
  always_comb begin
    if (state_r == ST_DIV) begin
      alu_a     = acc_r;
      alu_b     = PW'(cols_r);
      alu_limit = PW'(len_r);
    end else begin
      alu_a     = pos_r;
      alu_b     = stride_r;
      alu_limit = acc_r;
    end
  end

  ctc_alu #(
    .W (PW)
  ) u_alu (
    .op_a    (alu_a),
    .op_b    (alu_b),
    .limit   (alu_limit),
    .sum     (alu_sum),
    .reached (alu_reached)
  );

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    cols_nxt   = cols_r;
    dir_nxt    = dir_r;
    acc_nxt    = acc_r;
    rows_nxt   = rows_r;
    stride_nxt = stride_r;
    pos_nxt    = pos_r;
    base_nxt   = base_r;
    cnt_nxt    = cnt_r;
    vld_nxt    = 1'b0;
    pad_nxt    = pad_r;
    last_nxt   = last_r;
    oflag_nxt  = oflag_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (len_r < LW'(MAX_LEN)) begin
            len_nxt = len_r + LW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_item.in_last) begin
            cols_nxt  = (cfg.columns == '0) ? COLS_W'(1) : cfg.columns;
            dir_nxt   = cfg.direction;
            acc_nxt   = '0;
            rows_nxt  = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // repeated add of the column count until it covers the length
        acc_nxt  = alu_sum[PW-1:0];
        rows_nxt = rows_r + LW'(1);
        if (alu_reached) begin
          stride_nxt = dir_r ? PW'(rows_r + LW'(1)) : PW'(cols_r);
          pos_nxt    = '0;
          base_nxt   = '0;
          cnt_nxt    = '0;
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        vld_nxt   = 1'b1;
        pad_nxt   = (pos_r >= PW'(len_r));
        last_nxt  = is_last;
        oflag_nxt = ovf_r;
        cnt_nxt   = cnt_r + PW'(1);
        if (alu_reached) begin
          base_nxt = base_r + PW'(1);
          pos_nxt  = base_r + PW'(1);
        end else begin
          pos_nxt = alu_sum[PW-1:0];
        end
        if (is_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        len_nxt   = '0;
        ovf_nxt   = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      ovf_r   <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cols_r   <= cols_nxt;
    dir_r    <= dir_nxt;
    acc_r    <= acc_nxt;
    rows_r   <= rows_nxt;
    stride_r <= stride_nxt;
    pos_r    <= pos_nxt;
    base_r   <= base_nxt;
    cnt_r    <= cnt_nxt;
    pad_r    <= pad_nxt;
    last_r   <= last_nxt;
    oflag_r  <= oflag_nxt;
  end

  // zero bytes and positions past the message read as pad
  assign out_valid         = vld_r;
  assign out_item.out_char = (pad_r || (ram_rdata == 8'h00)) ? PAD_CHAR : ram_rdata;
  assign out_item.out_last = last_r;
  assign out_item.overflow = oflag_r;

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// testbench for the columnar transposition cipher unit: directed and random messages
`timescale 1ns / 100ps
module tb;
  import ctc_pkg::*;

  typedef struct {
    ctc_in_t     item;
    int unsigned gap;
  } plain_txn_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  ctc_in_t     in_item = '0;
  logic        out_valid;
  ctc_out_t    out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  columnar_transposition_cipher_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [7:0]        msg_buf [CTC_MAX_LEN];
  int                msg_len = 0;
  logic              msg_dropped = 1'b0;
  logic [COLS_W-1:0] grid_cols = 6'd1;
  logic              grid_dir = 1'b0;

  plain_txn_t plain_q[$];
  plain_txn_t cur_txn;
  ctc_out_t   pending_cipher[$];
  logic       in_taken = 1'b0;
  logic       failed = 1'b0;
  int         items_sent = 0;
  int         open_len = 0;
  int unsigned gap_max = 7;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("CHECK FAILED");
    $finish;
  end

  // store one byte; a final byte walks the padded grid and queues every result
  task automatic permute_message(input ctc_in_t it);
    int cols, rows, len, stride, pos, count;
    ctc_out_t r;
    if (msg_len < CTC_MAX_LEN) begin
      msg_buf[msg_len] = it.in_char;
      msg_len++;
    end else begin
      msg_dropped = 1'b1;
    end
    if (!it.in_last) return;
    cols = (grid_cols == 0) ? 1 : int'(grid_cols);
    rows = (msg_len + cols - 1) / cols;
    if (rows == 0) rows = 1;
    len = cols * rows;
    stride = grid_dir ? rows : cols;
    count = 0;
    for (int s = 0; s < stride; s++) begin
      for (pos = s; pos < len; pos += stride) begin
        r.out_char = PAD_CHAR;
        if (pos < msg_len && msg_buf[pos] != 8'h00) r.out_char = msg_buf[pos];
        r.out_last = (count + 1 == len);
        r.overflow = msg_dropped;
        pending_cipher.push_back(r);
        count++;
      end
    end
    msg_len = 0;
    msg_dropped = 1'b0;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !in_taken)) begin
      if (plain_q.size() == 0) begin
        start <= 1'b0;
      end else if (plain_q[0].gap != 0) begin
        start <= 1'b0;
        plain_q[0].gap = plain_q[0].gap - 1;
      end else begin
        cur_txn = plain_q.pop_front();
        in_item <= cur_txn.item;
        start <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    ctc_out_t want;
    if (rst_n && start && !busy) permute_message(in_item);
    in_taken <= rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (pending_cipher.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_item);
        failed = 1'b1;
      end else begin
        want = pending_cipher.pop_front();
        if (out_item.out_char !== want.out_char) begin
          $display("%0t: out_char expected %h, got %h", $time, want.out_char,
                   out_item.out_char);
          failed = 1'b1;
        end
        if (out_item.out_last !== want.out_last) begin
          $display("%0t: out_last expected %b, got %b", $time, want.out_last,
                   out_item.out_last);
          failed = 1'b1;
        end
        if (out_item.overflow !== want.overflow) begin
          $display("%0t: overflow expected %b, got %b", $time, want.overflow,
                   out_item.overflow);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic reg_write(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_COLUMNS) grid_cols = value[COLS_W-1:0];
    else grid_dir = value[0];
  endtask

  // upper data bits carry noise, only the field bits count
  task automatic set_grid(input int cols, input logic dir);
    reg_write(REG_COLUMNS, ($urandom & ~32'h3F) | 32'(cols));
    reg_write(REG_DIRECTION, ($urandom & ~32'h1) | 32'(dir));
  endtask

  task automatic send_byte(input logic [7:0] ch, input logic last);
    plain_txn_t t;
    t.item.in_char = ch;
    t.item.in_last = last;
    t.gap = $urandom_range(0, gap_max);
    plain_q.push_back(t);
    items_sent++;
  endtask

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 15) == 0) return 8'h00;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_message(input int n);
    for (int i = 0; i < n; i++) send_byte(rand_byte(), i == n - 1);
  endtask

  // block idle: all bytes taken, all results seen, walk finished
  task automatic wait_idle();
    while (plain_q.size() != 0 || start || pending_cipher.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  initial begin
    int phase, target, n, cols;
    int extreme_cols[5] = '{1, 32, 2, 63, 0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: default grid, a one-byte and a two-byte message at the byte extremes
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_idle();
    // short message with a zero byte, both directions
    set_grid(3, 1'b0);
    send_byte(8'h61, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h63, 1'b0); send_byte(8'h64, 1'b1);
    wait_idle();
    set_grid(3, 1'b1);
    send_byte(8'h61, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h63, 1'b0); send_byte(8'h64, 1'b1);
    wait_idle();
    // zero columns acts as one column
    set_grid(0, 1'b0);
    send_byte(8'h7E, 1'b0); send_byte(8'h81, 1'b1);
    wait_idle();
    // columns at and beyond the buffer size: one row, mostly pad
    set_grid(63, 1'b1);
    send_byte(8'h55, 1'b0); send_byte(8'hAA, 1'b0); send_byte(8'h01, 1'b1);
    wait_idle();
    set_grid(32, 1'b0);
    send_byte(8'hFE, 1'b1);
    wait_idle();
    // grid changes while a message is half loaded
    set_grid(5, 1'b0);
    send_byte(8'h10, 1'b0); send_byte(8'hEF, 1'b0);
    wait_idle();
    set_grid(2, 1'b1);
    send_byte(8'h42, 1'b1);
    wait_idle();

    items_sent = 0;
    phase = 0;
    while (items_sent < 250) begin
      if (phase < 5) begin
        cols = extreme_cols[phase];
      end else begin
        case ($urandom_range(0, 7))
          0: cols = 0;
          1: cols = $urandom_range(33, 63);
          default: cols = $urandom_range(1, 32);
        endcase
      end
      set_grid(cols, (phase < 4) ? phase[0] : 1'($urandom_range(0, 1)));
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      n = 0;
      while (n < 25) begin
        case ($urandom_range(0, 9))
          0: target = $urandom_range(33, 40);
          1: target = CTC_MAX_LEN;
          2, 3, 4: target = $urandom_range(1, 3);
          default: target = $urandom_range(1, 31);
        endcase
        if (phase == 0 && n == 0) target = 34;
        target = (target > open_len) ? target - open_len : 1;
        send_message(target);
        n += target;
        open_len = 0;
      end
      // leave a partial message open across the next grid change
      if (items_sent < 250 && $urandom_range(0, 2) == 0) begin
        open_len = $urandom_range(1, 5);
        for (int i = 0; i < open_len; i++) send_byte(rand_byte(), 1'b0);
      end
      wait_idle();
      phase++;
    end
    if (open_len != 0) begin
      send_byte(rand_byte(), 1'b1);
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (!failed && pending_cipher.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (pending_cipher.size() != 0)
        $display("%0t: %0d results expected but never seen", $time, pending_cipher.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- columnar_transposition_cipher_unit.f -----
hdl/ctc_pkg.sv
hdl/ctc_ram.sv
hdl/ctc_alu.sv
hdl/ctc_cfg.sv
hdl/ctc_seq.sv
hdl/columnar_transposition_cipher_unit.sv
test/tb.sv
